### sv/cgbl_pkg.sv
// Shared types and constants for the color grid blob locator.
`timescale 1ns / 1ps

package cgbl_pkg;

	// Field widths fixed by the data format
	localparam int SUM_W    = 20;
	localparam int IDX_W    = 8;
	localparam int N_W      = 12;
	localparam int CNT_W    = 14;
	localparam int ROWACC_W = 21;
	localparam int COLACC_W = 22;
	localparam int DIV_W    = 22;
	localparam int QDEPTH   = 4;
	localparam int QCNT_W   = 3;
	localparam int QPTR_W   = 2;

	// Register map (index = byte address / 4)
	localparam logic [2:0] REG_LINE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_CELL_WIDTH  = 3'd1;
	localparam logic [2:0] REG_CELL_HEIGHT = 3'd2;
	localparam logic [2:0] REG_RED_FLOOR   = 3'd3;
	localparam logic [2:0] REG_GREEN_FLOOR = 3'd4;
	localparam logic [2:0] REG_MIN_CELLS   = 3'd5;

	localparam logic [12:0] RST_LINE_WIDTH  = 13'd640;
	localparam logic [5:0]  RST_CELL_WIDTH  = 6'd4;
	localparam logic [6:0]  RST_CELL_HEIGHT = 7'd4;
	localparam logic [7:0]  RST_RED_FLOOR   = 8'd200;
	localparam logic [7:0]  RST_GREEN_FLOOR = 8'd150;
	localparam logic [13:0] RST_MIN_CELLS   = 14'd100;

	typedef struct packed {
		logic [7:0] blue_level;
		logic [7:0] green_level;
		logic [7:0] red_level;
		logic       frame_end;
	} pix_t;

	typedef struct packed {
		logic [13:0] red_cells;
		logic [6:0]  red_row_cell;
		logic [7:0]  red_col_cell;
		logic        red_found;
		logic [13:0] green_cells;
		logic [6:0]  green_row_cell;
		logic [7:0]  green_col_cell;
		logic        green_found;
	} res_t;

	typedef struct packed {
		logic [12:0] line_width;
		logic [5:0]  cell_width;
		logic [6:0]  cell_height;
		logic [7:0]  red_floor;
		logic [7:0]  green_floor;
		logic [13:0] min_cells;
	} cfg_t;

	// Work handed from the pixel front end to the divider back end
	typedef struct packed {
		logic             cell_v;
		logic             frame_end;
		logic [SUM_W-1:0] sum_b;
		logic [SUM_W-1:0] sum_g;
		logic [SUM_W-1:0] sum_r;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [N_W-1:0]   n;
		logic [7:0]       red_floor;
		logic [7:0]       green_floor;
		logic [13:0]      min_cells;
	} qent_t;

endpackage

### sv/cgbl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cgbl_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 160,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the old contents on a same-edge write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### sv/cgbl_front.sv
// Pixel front end: raster position, per-column cell sums, cell completion.
`timescale 1ns / 1ps

module cgbl_front
	import cgbl_pkg::*;
#(
	parameter int ROW_CELLS    = 90,
	parameter int COL_CELLS    = 160,
	parameter int MAX_CELL_DIM = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  pix_t              pix,
	input  cfg_t              cfg,
	input  logic              cfg_wr,
	input  logic [QCNT_W-1:0] q_count,
	output logic              q_push,
	output qent_t             q_ent,
	output logic              busy
);

	localparam int AW = (COL_CELLS > 1) ? $clog2(COL_CELLS) : 1;
	localparam int BW = $clog2(ROW_CELLS + 1);
	localparam int SW = 3 * SUM_W;

	// Position state
	logic [12:0]   pc_q, col_q;
	logic [5:0]    off_q, lib_q;
	logic [BW-1:0] band_q;

	// Column/offset recompute after a register write
	logic        busy_q;
	logic [3:0]  rc_cnt_q;
	logic [12:0] rc_dq_q;
	logic [5:0]  rc_rem_q;
	logic [6:0]  rc_t;
	logic        rc_ge;

	// Stage 1
	logic             v_s1, ingrid_s1, first_s1, last_s1, fend_s1;
	logic [AW-1:0]    addr_s1;
	logic [IDX_W-1:0] row_s1, col_s1;
	logic [7:0]       b_s1, g_s1, r_s1;
	logic [N_W-1:0]   n_s1;
	logic [7:0]       rf_s1, gf_s1;
	logic [13:0]      mc_s1;

	// Write bypass and per-column written flags
	logic                 byp_v_q;
	logic [AW-1:0]        byp_addr_q;
	logic [SW-1:0]        byp_data_q;
	logic [COL_CELLS-1:0] vld_q;

	logic [5:0]    cw;
	logic [6:0]    ch;
	logic [12:0]   lw;
	logic [12:0]   n_full;
	logic          accept, in_grid, first, last, wrap_line;
	logic [6:0]    lib_nx;
	logic [6:0]    off_nx;
	logic [SW-1:0] rd_data, old_sums, new_sums;
	logic [SUM_W-1:0] old_b, old_g, old_r, new_b, new_g, new_r;
	logic          wr_en;

	// Effective register values
	always_comb begin
		cw = (cfg.cell_width == 6'd0) ? 6'd1 : cfg.cell_width;
		if (cfg.cell_height == 7'd0) begin
			ch = 7'd1;
		end else if (cfg.cell_height > 7'(MAX_CELL_DIM)) begin
			ch = 7'(MAX_CELL_DIM);
		end else begin
			ch = cfg.cell_height;
		end
		lw = (cfg.line_width == 13'd0) ? 13'd1 : cfg.line_width;
		n_full = {7'd0, cw} * {6'd0, ch};
	end

	assign pix_stall = busy_q || ({1'b0, q_count} + {3'd0, v_s1} >= 4'(QDEPTH));
	assign accept    = pix_valid && !pix_stall;
	assign busy      = busy_q;

	// Classification of the current pixel position
	always_comb begin
		in_grid   = (band_q < BW'(ROW_CELLS)) && (col_q < 13'(COL_CELLS))
			&& ({1'b0, lib_q} < ch);
		first     = (lib_q == 6'd0) && (off_q == 6'd0);
		last      = ({1'b0, lib_q} == ch - 7'd1) && (off_q == cw - 6'd1);
		wrap_line = ({1'b0, pc_q} + 14'd1) >= {1'b0, lw};
		lib_nx    = {1'b0, lib_q} + 7'd1;
		off_nx    = {1'b0, off_q} + 7'd1;
		rc_t      = {rc_rem_q, rc_dq_q[12]};
		rc_ge     = rc_t >= {1'b0, cw};
	end

	// Position counters and recompute divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= '0;
			col_q    <= '0;
			off_q    <= '0;
			lib_q    <= '0;
			band_q   <= '0;
			busy_q   <= 1'b0;
			rc_cnt_q <= '0;
		end else if (cfg_wr) begin
			busy_q   <= 1'b1;
			rc_cnt_q <= 4'd13;
			rc_dq_q  <= pc_q;
			rc_rem_q <= '0;
		end else if (busy_q) begin
			if (rc_cnt_q != 4'd0) begin
				rc_cnt_q <= rc_cnt_q - 4'd1;
				rc_dq_q  <= {rc_dq_q[11:0], rc_ge};
				rc_rem_q <= rc_ge ? 6'(rc_t - {1'b0, cw}) : rc_t[5:0];
			end else begin
				busy_q <= 1'b0;
				col_q  <= rc_dq_q;
				off_q  <= rc_rem_q;
			end
		end else if (accept) begin
			if (pix.frame_end) begin
				pc_q   <= '0;
				col_q  <= '0;
				off_q  <= '0;
				lib_q  <= '0;
				band_q <= '0;
			end else if (wrap_line) begin
				pc_q  <= '0;
				col_q <= '0;
				off_q <= '0;
				if (lib_nx >= ch) begin
					lib_q <= '0;
					if (band_q < BW'(ROW_CELLS)) begin
						band_q <= band_q + BW'(1);
					end
				end else begin
					lib_q <= lib_nx[5:0];
				end
			end else begin
				pc_q <= pc_q + 13'd1;
				if (off_nx >= {1'b0, cw}) begin
					off_q <= '0;
					col_q <= col_q + 13'd1;
				end else begin
					off_q <= off_nx[5:0];
				end
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ingrid_s1 <= in_grid;
			first_s1  <= first;
			last_s1   <= last;
			fend_s1   <= pix.frame_end;
			addr_s1   <= col_q[AW-1:0];
			row_s1    <= IDX_W'(band_q);
			col_s1    <= col_q[IDX_W-1:0];
			b_s1      <= pix.blue_level;
			g_s1      <= pix.green_level;
			r_s1      <= pix.red_level;
			n_s1      <= n_full[N_W-1:0];
			rf_s1     <= cfg.red_floor;
			gf_s1     <= cfg.green_floor;
			mc_s1     <= cfg.min_cells;
		end
	end

	cgbl_ram #(
		.WIDTH(SW),
		.DEPTH(COL_CELLS),
		.AW   (AW)
	) u_sums (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(addr_s1),
		.wr_data(last_s1 ? '0 : new_sums),
		.rd_en  (accept),
		.rd_addr(col_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// Read-modify-write of the column sums
	always_comb begin
		if (!vld_q[addr_s1]) begin
			old_sums = '0;
		end else if (byp_v_q && (byp_addr_q == addr_s1)) begin
			old_sums = byp_data_q;
		end else begin
			old_sums = rd_data;
		end
		{old_b, old_g, old_r} = old_sums;
		new_b = first_s1 ? {12'd0, b_s1} : old_b + {12'd0, b_s1};
		new_g = first_s1 ? {12'd0, g_s1} : old_g + {12'd0, g_s1};
		new_r = first_s1 ? {12'd0, r_s1} : old_r + {12'd0, r_s1};
		new_sums = {new_b, new_g, new_r};
		wr_en = v_s1 && ingrid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_v_q <= 1'b0;
			vld_q   <= '0;
		end else if (wr_en) begin
			byp_v_q        <= 1'b1;
			vld_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byp_addr_q <= addr_s1;
			byp_data_q <= last_s1 ? '0 : new_sums;
		end
	end

	// Hand completed cells and frame ends to the queue
	always_comb begin
		q_push            = v_s1 && ((ingrid_s1 && last_s1) || fend_s1);
		q_ent.cell_v      = ingrid_s1 && last_s1;
		q_ent.frame_end   = fend_s1;
		q_ent.sum_b       = new_b;
		q_ent.sum_g       = new_g;
		q_ent.sum_r       = new_r;
		q_ent.row         = row_s1;
		q_ent.col         = col_s1;
		q_ent.n           = n_s1;
		q_ent.red_floor   = rf_s1;
		q_ent.green_floor = gf_s1;
		q_ent.min_cells   = mc_s1;
	end

endmodule

### sv/cgbl_queue.sv
// Short FIFO between the pixel front end and the divider back end.
`timescale 1ns / 1ps

module cgbl_queue
	import cgbl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qent_t             ent_in,
	input  logic              pop,
	output qent_t             ent_out,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;

	assign ent_out = mem_q[rd_q];
	assign empty   = (count_q == '0);
	assign count   = count_q;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= ent_in;
		end
	end

endmodule

### sv/cgbl_back.sv
// Back end: bit-serial cell averaging, color tests, centroid division, result register.
`timescale 1ns / 1ps

module cgbl_back
	import cgbl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_empty,
	input  qent_t q_ent,
	output logic  q_pop,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CDIV,
		ST_FLOAD,
		ST_FDIV,
		ST_EMIT
	} state_t;

	state_t state_q;
	qent_t  e_q;
	logic   pass_q;
	logic [4:0] step_q;

	// Three divider lanes sharing one divisor
	logic [DIV_W-1:0] dq_q  [3];
	logic [CNT_W-1:0] rem_q [3];
	logic [CNT_W-1:0] div_q;
	logic [DIV_W-1:0] dq_nx  [3];
	logic [CNT_W-1:0] rem_nx [3];
	logic [CNT_W:0]   t      [3];
	logic             ge     [3];

	logic [CNT_W-1:0]    rcnt_q, gcnt_q;
	logic [ROWACC_W-1:0] rrow_q, grow_q;
	logic [COLACC_W-1:0] rcol_q, gcol_q;
	logic [6:0]          rrow_res_q, grow_res_q;
	logic [7:0]          rcol_res_q, gcol_res_q;

	logic              res_valid_q;
	res_t              res_q;
	logic              is_red, is_green;
	logic [DIV_W+3:0]  ab10, ar10, ag9;
	logic [DIV_W:0]    ab2, ag2;
	logic [6:0]        row_res;
	logic [7:0]        col_res;
	logic              out_free;

	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_free  = !res_valid_q || !res_stall;

	// One restoring step per lane
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t[i]      = {rem_q[i], dq_q[i][DIV_W-1]};
			ge[i]     = t[i] >= {1'b0, div_q};
			rem_nx[i] = ge[i] ? CNT_W'(t[i] - {1'b0, div_q}) : t[i][CNT_W-1:0];
			dq_nx[i]  = {dq_q[i][DIV_W-2:0], ge[i]};
		end
	end

	// Color tests on the averaged channels (lanes: blue, green, red)
	always_comb begin
		ab2  = {dq_q[0], 1'b0};
		ag2  = {dq_q[1], 1'b0};
		ab10 = (DIV_W+4)'(dq_q[0]) * (DIV_W+4)'(10);
		ar10 = (DIV_W+4)'(dq_q[2]) * (DIV_W+4)'(10);
		ag9  = (DIV_W+4)'(dq_q[1]) * (DIV_W+4)'(9);
		is_red = (dq_q[2] > DIV_W'(e_q.red_floor)) && (ag2 < {1'b0, dq_q[2]})
			&& (ab2 < {1'b0, dq_q[2]});
		is_green = (dq_q[1] > DIV_W'(e_q.green_floor)) && (ar10 <= ag9) && (ab10 <= ag9);
		row_res = (div_q == '0) ? 7'd0 : dq_q[0][6:0];
		col_res = (div_q == '0) ? 8'd0 : dq_q[1][7:0];
	end

	// Sequencer with accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= 1'b0;
			step_q      <= '0;
			rcnt_q      <= '0;
			rrow_q      <= '0;
			rcol_q      <= '0;
			gcnt_q      <= '0;
			grow_q      <= '0;
			gcol_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// Result beat: raised when loaded, dropped once taken
			if (state_q == ST_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						e_q <= q_ent;
						if (q_ent.cell_v) begin
							dq_q[0]  <= DIV_W'(q_ent.sum_b);
							dq_q[1]  <= DIV_W'(q_ent.sum_g);
							dq_q[2]  <= DIV_W'(q_ent.sum_r);
							rem_q[0] <= '0;
							rem_q[1] <= '0;
							rem_q[2] <= '0;
							div_q    <= CNT_W'(q_ent.n);
							step_q   <= 5'(DIV_W);
							state_q  <= ST_CDIV;
						end else begin
							pass_q  <= 1'b0;
							state_q <= ST_FLOAD;
						end
					end
				end
				ST_CDIV: begin
					if (step_q != '0) begin
						step_q <= step_q - 5'd1;
						for (int i = 0; i < 3; i++) begin
							dq_q[i]  <= dq_nx[i];
							rem_q[i] <= rem_nx[i];
						end
					end else begin
						if (is_red) begin
							rcnt_q <= rcnt_q + CNT_W'(1);
							rrow_q <= rrow_q + ROWACC_W'(e_q.row);
							rcol_q <= rcol_q + COLACC_W'(e_q.col);
						end
						if (is_green) begin
							gcnt_q <= gcnt_q + CNT_W'(1);
							grow_q <= grow_q + ROWACC_W'(e_q.row);
							gcol_q <= gcol_q + COLACC_W'(e_q.col);
						end
						pass_q  <= 1'b0;
						state_q <= e_q.frame_end ? ST_FLOAD : ST_IDLE;
					end
				end
				ST_FLOAD: begin
					dq_q[0]  <= DIV_W'(pass_q ? grow_q : rrow_q);
					dq_q[1]  <= pass_q ? gcol_q : rcol_q;
					dq_q[2]  <= '0;
					rem_q[0] <= '0;
					rem_q[1] <= '0;
					rem_q[2] <= '0;
					div_q    <= pass_q ? gcnt_q : rcnt_q;
					step_q   <= 5'(DIV_W);
					state_q  <= ST_FDIV;
				end
				ST_FDIV: begin
					if (step_q != '0) begin
						step_q <= step_q - 5'd1;
						for (int i = 0; i < 3; i++) begin
							dq_q[i]  <= dq_nx[i];
							rem_q[i] <= rem_nx[i];
						end
					end else if (!pass_q) begin
						rrow_res_q <= row_res;
						rcol_res_q <= col_res;
						pass_q     <= 1'b1;
						state_q    <= ST_FLOAD;
					end else begin
						grow_res_q <= row_res;
						gcol_res_q <= col_res;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						res_q.red_cells      <= rcnt_q;
						res_q.red_row_cell   <= rrow_res_q;
						res_q.red_col_cell   <= rcol_res_q;
						res_q.red_found      <= rcnt_q > e_q.min_cells;
						res_q.green_cells    <= gcnt_q;
						res_q.green_row_cell <= grow_res_q;
						res_q.green_col_cell <= gcol_res_q;
						res_q.green_found    <= gcnt_q > e_q.min_cells;
						rcnt_q  <= '0;
						rrow_q  <= '0;
						rcol_q  <= '0;
						gcnt_q  <= '0;
						grow_q  <= '0;
						gcol_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### sv/color_grid_blob_locator_core.sv
// Top level: configuration registers and the front end, queue and back end.
`timescale 1ns / 1ps

// Color grid blob locator.
// Pixels (blue, green, red, frame_end) enter on the pix channel in raster
// order; a beat moves when pix_valid is high and pix_stall is low. The grid
// of cells is averaged per channel; cells passing the red or green test are
// counted and their row/column indices summed.
// One result beat appears on res per pixel that carries frame_end.
// Throughput: one pixel per clock while the four-entry queue has room and no
// recompute runs. Each completed cell occupies the back end for a queue pop
// and the three-lane bit-serial divider, so cells completing faster than the
// back end can take them stall the input.
// res_valid rises once the frame_end pixel has passed the queue and the two
// centroid divisions (red, then green), after a cell division first when that
// pixel also completes a cell, plus any queued work.
// A write over the APB port stalls pixel input while the column position is
// recomputed. Reset clears all counters, the queue and the per-column written
// flags; registers return to their defaults.
// While res_stall is high the finished result is held; the back end works on
// queued cells until the next result and the front end takes pixels until full.

module color_grid_blob_locator_core
	import cgbl_pkg::*;
#(
	parameter int ROW_CELLS    = 90,
	parameter int COL_CELLS    = 160,
	parameter int MAX_CELL_DIM = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pix_valid,
	output logic        pix_stall,
	input  pix_t        pix,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t              cfg_q;
	logic              cfg_wr;
	logic [2:0]        reg_idx;
	logic              q_push, q_pop, q_empty, front_busy;
	qent_t             q_in, q_out;
	logic [QCNT_W-1:0] q_count;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width  <= RST_LINE_WIDTH;
			cfg_q.cell_width  <= RST_CELL_WIDTH;
			cfg_q.cell_height <= RST_CELL_HEIGHT;
			cfg_q.red_floor   <= RST_RED_FLOOR;
			cfg_q.green_floor <= RST_GREEN_FLOOR;
			cfg_q.min_cells   <= RST_MIN_CELLS;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LINE_WIDTH:  cfg_q.line_width  <= pwdata[12:0];
				REG_CELL_WIDTH:  cfg_q.cell_width  <= pwdata[5:0];
				REG_CELL_HEIGHT: cfg_q.cell_height <= pwdata[6:0];
				REG_RED_FLOOR:   cfg_q.red_floor   <= pwdata[7:0];
				REG_GREEN_FLOOR: cfg_q.green_floor <= pwdata[7:0];
				REG_MIN_CELLS:   cfg_q.min_cells   <= pwdata[13:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			REG_LINE_WIDTH:  prdata = {19'd0, cfg_q.line_width};
			REG_CELL_WIDTH:  prdata = {26'd0, cfg_q.cell_width};
			REG_CELL_HEIGHT: prdata = {25'd0, cfg_q.cell_height};
			REG_RED_FLOOR:   prdata = {24'd0, cfg_q.red_floor};
			REG_GREEN_FLOOR: prdata = {24'd0, cfg_q.green_floor};
			REG_MIN_CELLS:   prdata = {18'd0, cfg_q.min_cells};
			default:         prdata = '0;
		endcase
	end

	cgbl_front #(
		.ROW_CELLS   (ROW_CELLS),
		.COL_CELLS   (COL_CELLS),
		.MAX_CELL_DIM(MAX_CELL_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix      (pix),
		.cfg      (cfg_q),
		.cfg_wr   (cfg_wr),
		.q_count  (q_count),
		.q_push   (q_push),
		.q_ent    (q_in),
		.busy     (front_busy)
	);

	cgbl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.ent_in (q_in),
		.pop    (q_pop),
		.ent_out(q_out),
		.empty  (q_empty),
		.count  (q_count)
	);

	cgbl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_ent    (q_out),
		.q_pop    (q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	// Queue never takes a beat while full unless one is popped in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_count < QCNT_W'(QDEPTH) || q_pop))
		else $error("queue overflow");

	// Found flags agree with the counts
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.red_found == (res.red_cells > cfg_q.min_cells))
			&& (res.green_found == (res.green_cells > cfg_q.min_cells)))
		else $error("found flag mismatch");

	// Empty color gives a zero centroid
	a_zero_centroid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.red_cells == 14'd0) |->
			(res.red_row_cell == 7'd0 && res.red_col_cell == 8'd0))
		else $error("nonzero centroid with no red cells");

	// Pixel input is held off during position recompute
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		front_busy |-> pix_stall)
		else $error("pixel taken during recompute");

endmodule
